@@ rtl/b64sc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_pkg
// word types and alphabet mapping shared by the base64 stream codec
// ----------------------------------------------------------------------------
package b64sc_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_has_data;
        logic       out_last;
    } out_word_t;

    // results of one item: first word, second word and how many are real
    typedef struct packed {
        out_word_t  r0;
        out_word_t  r1;
        logic [1:0] n;
    } res_t;

    // result queue status towards the top level
    typedef struct packed {
        logic [2:0] level;
        logic       room;
    } fifo_status_t;

    localparam int unsigned FIFO_DEPTH = 4;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26)
            c = 8'(w + 8'd65);
        else if (v < 6'd52)
            c = 8'(w + 8'd71);
        else if (v < 6'd62)
            c = 8'(w - 8'd4);
        else if (v == 6'd62)
            c = 8'd43;
        else
            c = 8'd47;
        return c;
    endfunction

    // anything outside the alphabet, the pad character included, reads as zero
    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [5:0] v;
        case (c) inside
            [8'd65:8'd90]:  v = 6'(c - 8'd65);
            [8'd97:8'd122]: v = 6'(c - 8'd71);
            [8'd48:8'd57]:  v = 6'(c + 8'd4);
            8'd43:          v = 6'd62;
            8'd47:          v = 6'd63;
            default:        v = 6'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/b64sc_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_core
// group phase and carry bits, and the result words of one item
// ----------------------------------------------------------------------------
module b64sc_core
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire logic                clear,
    input  wire logic                decode_mode,
    input  wire b64sc_pkg::in_word_t item,
    output b64sc_pkg::res_t          res
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;
    localparam logic [1:0] PH_THREE = 2'd3;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [5:0] carry_reg;
    logic [5:0] carry_next;
    logic [7:0] b;
    logic [5:0] v;

    assign b = item.in_byte;
    assign v = b64sc_pkg::char_to_sextet(b);

    always_comb
    begin
        res        = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        if (!decode_mode)
        begin
            case (phase_reg)
                PH_ONE:
                begin
                    res.r0     = '{b64sc_pkg::sextet_to_char({carry_reg[1:0], b[7:4]}),
                                   1'b1, 1'b0};
                    res.r1     = '{b64sc_pkg::sextet_to_char({b[3:0], 2'b00}), 1'b1, 1'b0};
                    res.n      = item.in_last ? 2'd2 : 2'd1;
                    carry_next = {2'b00, b[3:0]};
                    phase_next = PH_TWO;
                end
                PH_TWO:
                begin
                    res.r0     = '{b64sc_pkg::sextet_to_char({carry_reg[3:0], b[7:6]}),
                                   1'b1, 1'b0};
                    res.r1     = '{b64sc_pkg::sextet_to_char(b[5:0]), 1'b1, 1'b0};
                    res.n      = 2'd2;
                    carry_next = '0;
                    phase_next = PH_START;
                end
                default:
                begin
                    // phase three never arises here and is taken as a group start
                    res.r0     = '{b64sc_pkg::sextet_to_char(b[7:2]), 1'b1, 1'b0};
                    res.r1     = '{b64sc_pkg::sextet_to_char({b[1:0], 4'b0000}), 1'b1, 1'b0};
                    res.n      = item.in_last ? 2'd2 : 2'd1;
                    carry_next = {4'b0000, b[1:0]};
                    phase_next = PH_ONE;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    // lone trailing character gives an empty end marker
                    res.r0     = '{8'd0, 1'b0, 1'b0};
                    res.n      = item.in_last ? 2'd1 : 2'd0;
                    carry_next = v;
                    phase_next = PH_ONE;
                end
                PH_ONE:
                begin
                    res.r0     = '{{carry_reg, v[5:4]}, 1'b1, 1'b0};
                    res.n      = 2'd1;
                    carry_next = {2'b00, v[3:0]};
                    phase_next = PH_TWO;
                end
                PH_TWO:
                begin
                    res.r0     = '{{carry_reg[3:0], v[5:2]}, 1'b1, 1'b0};
                    res.n      = 2'd1;
                    carry_next = {4'b0000, v[1:0]};
                    phase_next = PH_THREE;
                end
                default:
                begin
                    res.r0     = '{{carry_reg[1:0], v}, 1'b1, 1'b0};
                    res.n      = 2'd1;
                    carry_next = '0;
                    phase_next = PH_START;
                end
            endcase
        end
        if (item.in_last)
        begin
            if (res.n == 2'd1)
                res.r0.out_last = 1'b1;
            if (res.n == 2'd2)
                res.r1.out_last = 1'b1;
            carry_next = '0;
            phase_next = PH_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            carry_reg <= '0;
        end
        else if (clear)
        begin
            phase_reg <= PH_START;
            carry_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/b64sc_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_fifo
// result queue taking up to two words per cycle and giving one while not stalled
// ----------------------------------------------------------------------------
module b64sc_fifo
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire b64sc_pkg::res_t      res,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output b64sc_pkg::out_word_t      out_data,
    output b64sc_pkg::fifo_status_t   status
);

    localparam int unsigned PW = $clog2(b64sc_pkg::FIFO_DEPTH);
    localparam int unsigned LW = $clog2(b64sc_pkg::FIFO_DEPTH + 1);

    b64sc_pkg::out_word_t mem_reg [b64sc_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] wr_ptr_one;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;
    logic [1:0]    n_push;
    logic          pop;

    assign n_push      = push ? res.n : 2'd0;
    assign pop         = out_valid && !out_stall;
    assign wr_ptr_one  = PW'(wr_ptr_reg + 1'b1);
    assign wr_ptr_next = PW'(wr_ptr_reg + n_push);
    assign rd_ptr_next = PW'(rd_ptr_reg + pop);
    assign level_next  = LW'(level_reg + LW'(n_push) - LW'(pop));

    assign out_valid    = (level_reg != '0);
    assign out_data     = mem_reg[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.room  = (level_reg <= LW'(b64sc_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem_reg[wr_ptr_reg] <= res.r0;
        if (n_push == 2'd2)
            mem_reg[wr_ptr_one] <= res.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/base64_stream_codec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec
// streaming base64 encoder and decoder, standard alphabet, no padding
// ----------------------------------------------------------------------------
//
//  channel   | direction | word                      | handshake
//  ----------+-----------+---------------------------+------------------------
//  in        | in        | in_byte, in_last          | in_valid / in_stall
//  out       | out       | out_byte, has_data, last  | out_valid / out_stall
//  apb       | in / out  | decode_mode at address 0  | psel, penable, pready
//
//  one input word is taken per cycle into the input register while in_stall
//  is low; from there it passes through the codec logic once the queue has room,
//  and its result words, none, one or two, land in a four-word result queue,
//  which sends one word per cycle while out_stall is low; encoding gives four
//  characters per three bytes, so the result port limits the long-run rate;
//  decoding gives at most one byte per character
//  in_stall rises only while the input register holds a word and the queue
//  has fewer than two free places, so a stalled result port backs up here
//  reset clears the queue, the input register, the group state and the mode
//
// ----------------------------------------------------------------------------
module base64_stream_codec
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input words
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire b64sc_pkg::in_word_t   in_data,
    // result words
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output b64sc_pkg::out_word_t       out_data,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // register index: byte address divided by four
    localparam logic REG_DECODE_MODE = 1'b0;

    logic                    decode_mode_reg;
    logic                    cfg_write;
    logic                    st_valid_reg;
    logic                    st_valid_next;
    b64sc_pkg::in_word_t     st_item_reg;
    logic                    accept_in;
    logic                    advance;
    b64sc_pkg::res_t         res;
    b64sc_pkg::fifo_status_t fifo_status;

    // ------------------------------------------------------------------
    // configuration port, zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DECODE_MODE);
    assign prdata    = (paddr[2] == REG_DECODE_MODE) ? {31'd0, decode_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decode_mode_reg <= 1'b0;
        else if (cfg_write)
            decode_mode_reg <= pwdata[0];
    end

    // ------------------------------------------------------------------
    // input register: moves on whenever the queue can take two words
    // ------------------------------------------------------------------
    assign advance       = st_valid_reg && fifo_status.room;
    assign in_stall      = st_valid_reg && !fifo_status.room;
    assign accept_in     = in_valid && !in_stall;
    assign st_valid_next = accept_in || (st_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else
            st_valid_reg <= st_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
            st_item_reg <= in_data;
    end

    // ------------------------------------------------------------------
    // codec logic and group state
    // ------------------------------------------------------------------
    b64sc_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .clear       (cfg_write),
        .decode_mode (decode_mode_reg),
        .item        (st_item_reg),
        .res         (res)
    );

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    b64sc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .status    (fifo_status)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_status.level <= 3'(b64sc_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_encode_emits: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !decode_mode_reg |-> res.n != 2'd0)
        else $error("encoded byte gave no character");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.n != 2'd0 |=> out_valid)
        else $error("pushed result not offered");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        advance && st_item_reg.in_last && res.n != 2'd0 |->
        (res.n == 2'd1 && res.r0.out_last) || (res.n == 2'd2 && res.r1.out_last))
        else $error("final result not marked last");

endmodule
`default_nettype wire

@@ sim/tb_base64_stream_codec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_codec
// self-checking testbench for the streaming base64 encoder and decoder
//
// every accepted input word runs through a behavioural codec kept in the
// bench, which queues the result words it should give; every accepted result
// word is checked field by field against the oldest queued word. directed
// groups cover the alphabet edges, flushes, the empty end marker and mode
// writes that abandon a group; random sequences with idle and stall bursts
// follow, ending with a stretch of full-rate traffic
// ----------------------------------------------------------------------------
module tb_base64_stream_codec;

    // codec direction as held in the mode register
    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } codec_mode_t;

    // register map: the mode register at index 0, nothing at index 1
    localparam logic [2:0] ADDR_DECODE_MODE = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

    // settle time, safely past any word still in the input register or the queue
    localparam int SETTLE_CYCLES  = 4;
    // longest legal quiet spell is a burst plus the settle time and a register access
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 100;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    b64sc_pkg::in_word_t  in_data   = '0;
    logic                 out_stall = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [2:0]           paddr     = '0;
    logic [31:0]          pwdata    = '0;

    logic                 in_stall;
    logic                 out_valid;
    b64sc_pkg::out_word_t out_data;
    logic [31:0]          prdata;
    logic                 pready;

    base64_stream_codec dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // behavioural codec state and the result words it still owes
    // ------------------------------------------------------------------------
    codec_mode_t          pred_mode  = MODE_ENCODE;
    logic [1:0]           pred_phase = 2'd0;
    logic [5:0]           pred_carry = 6'd0;
    b64sc_pkg::out_word_t pending_words[$];

    int error_count = 0;
    // chance in percent of an idle burst per input word and per result cycle
    int gap_pct     = 0;
    int stall_pct   = 0;

    task automatic note_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_REPORTS)
            $display("MISMATCH at %0t: %s, got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        error_count++;
    endtask

    // standard alphabet, written out from the character ranges
    function automatic logic [7:0] b64_char_of(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return "A" + w;
        else if (v < 6'd52)
            return "a" + w - 8'd26;
        else if (v < 6'd62)
            return "0" + w - 8'd52;
        else if (v == 6'd62)
            return "+";
        else
            return "/";
    endfunction

    // anything outside the alphabet, pad included, decodes as zero
    function automatic logic [5:0] b64_value_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return 6'(c - "A");
        else if (c >= "a" && c <= "z")
            return 6'(c - "a" + 8'd26);
        else if (c >= "0" && c <= "9")
            return 6'(c - "0" + 8'd52);
        else if (c == "+")
            return 6'd62;
        else if (c == "/")
            return 6'd63;
        else
            return 6'd0;
    endfunction

    function automatic b64sc_pkg::out_word_t data_word(input logic [7:0] b);
        return b64sc_pkg::out_word_t'{out_byte: b, out_has_data: 1'b1, out_last: 1'b0};
    endfunction

    // advance the behavioural codec by one accepted word, queue what it owes
    task automatic predict_codec(input b64sc_pkg::in_word_t w);
        b64sc_pkg::out_word_t res[2];
        int                   n;
        logic [7:0]           b;
        logic [5:0]           v;
        n = 0;
        b = w.in_byte;
        if (pred_mode == MODE_ENCODE)
        begin
            case (pred_phase)
                2'd1:
                begin
                    res[n++]   = data_word(b64_char_of({pred_carry[1:0], b[7:4]}));
                    pred_carry = {2'b00, b[3:0]};
                    pred_phase = 2'd2;
                    // flush of a two-byte tail
                    if (w.in_last)
                        res[n++] = data_word(b64_char_of({pred_carry[3:0], 2'b00}));
                end
                2'd2:
                begin
                    res[n++]   = data_word(b64_char_of({pred_carry[3:0], b[7:6]}));
                    res[n++]   = data_word(b64_char_of(b[5:0]));
                    pred_carry = 6'd0;
                    pred_phase = 2'd0;
                end
                default:
                begin
                    // phase 3 never arises when encoding, it behaves as phase 0
                    res[n++]   = data_word(b64_char_of(b[7:2]));
                    pred_carry = {4'b0000, b[1:0]};
                    pred_phase = 2'd1;
                    // flush of a one-byte tail
                    if (w.in_last)
                        res[n++] = data_word(b64_char_of({pred_carry[1:0], 4'b0000}));
                end
            endcase
        end
        else
        begin
            v = b64_value_of(b);
            case (pred_phase)
                2'd0:
                begin
                    pred_carry = v;
                    pred_phase = 2'd1;
                    // lone trailing character gives only an empty end marker
                    if (w.in_last)
                        res[n++] = b64sc_pkg::out_word_t'{out_byte: 8'd0,
                                                          out_has_data: 1'b0,
                                                          out_last: 1'b0};
                end
                2'd1:
                begin
                    res[n++]   = data_word({pred_carry, v[5:4]});
                    pred_carry = {2'b00, v[3:0]};
                    pred_phase = 2'd2;
                end
                2'd2:
                begin
                    res[n++]   = data_word({pred_carry[3:0], v[5:2]});
                    pred_carry = {4'b0000, v[1:0]};
                    pred_phase = 2'd3;
                end
                default:
                begin
                    res[n++]   = data_word({pred_carry[1:0], v});
                    pred_carry = 6'd0;
                    pred_phase = 2'd0;
                end
            endcase
        end
        // end of sequence: mark the final word, drop leftover bits
        if (w.in_last)
        begin
            if (n > 0)
                res[n - 1].out_last = 1'b1;
            pred_phase = 2'd0;
            pred_carry = 6'd0;
        end
        for (int i = 0; i < n; i++)
            pending_words.push_back(res[i]);
    endtask

    // ------------------------------------------------------------------------
    // result side: check each accepted word, then pick next cycle's stall
    // ------------------------------------------------------------------------
    initial
    begin : result_checker
        b64sc_pkg::out_word_t want;
        int                   stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                    note_mismatch("result word with none outstanding", out_data, 0);
                else
                begin
                    want = pending_words.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        note_mismatch("out_byte", out_data.out_byte, want.out_byte);
                    if (out_data.out_has_data !== want.out_has_data)
                        note_mismatch("out_has_data", out_data.out_has_data,
                                      want.out_has_data);
                    if (out_data.out_last !== want.out_last)
                        note_mismatch("out_last", out_data.out_last, want.out_last);
                end
            end
            // stall bursts, their remaining length counted down in stall_left
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 16);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without a word moving on either channel
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one word, optionally after an idle burst, and wait until taken
    // valid stays high on return; the next call or a pause decides its fate
    task automatic send_word(input logic [7:0] b, input logic is_last);
        b64sc_pkg::in_word_t w;
        w = b64sc_pkg::in_word_t'{in_byte: b, in_last: is_last};
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_codec(w);
    endtask

    task automatic send_chars(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // hold the input until every owed result word has come back
    // always waits for a clock edge first so valid is never lowered and raised at once
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // a mode write also abandons any partial group
        if (addr == ADDR_DECODE_MODE)
        begin
            pred_mode  = codec_mode_t'(data[0]);
            pred_phase = 2'd0;
            pred_carry = 6'd0;
        end
    endtask

    task automatic check_mode_readback();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DECODE_MODE;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {31'd0, pred_mode})
            note_mismatch("decode_mode readback", got, pred_mode);
    endtask

    // mode change only with the codec idle and nothing left in flight
    task automatic set_codec_mode(input codec_mode_t m);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(ADDR_DECODE_MODE, {31'd0, m});
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset value, a write to the empty index, both mode values
    task automatic test_mode_register();
        check_mode_readback();
        apb_write(ADDR_UNMAPPED, 32'd1);
        check_mode_readback();
        apb_write(ADDR_DECODE_MODE, {31'd0, MODE_DECODE});
        check_mode_readback();
        apb_write(ADDR_DECODE_MODE, {31'd0, MODE_ENCODE});
        check_mode_readback();
    endtask

    task automatic test_encode_directed();
        set_codec_mode(MODE_ENCODE);
        // one-byte tail flush
        send_word(8'h00, 1'b1);
        // two-byte tail flush
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        // full group of plus signs, last on a group boundary
        send_word(8'hFB, 1'b0);
        send_word(8'hEF, 1'b0);
        send_word(8'hBE, 1'b1);
        // full group of slashes, then a pause mid-sequence until all words are back
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        wait_results_drained();
        send_word(8'h00, 1'b0);
        send_word(8'h80, 1'b1);
        // partial group dropped by rewriting the same mode
        send_word(8'h4D, 1'b0);
        set_codec_mode(MODE_ENCODE);
        send_word(8'h61, 1'b1);
    endtask

    task automatic test_decode_directed();
        set_codec_mode(MODE_DECODE);
        stall_pct = 20;
        // alphabet edges, then a pad character alone at the end
        send_chars("AZaz09+/", 1'b0);
        send_word("=", 1'b1);
        // character outside the alphabet closing a three-character tail
        send_chars("Qx", 1'b0);
        send_word(8'hFF, 1'b1);
        // one character into a group, dropped by a mode write
        send_chars("T", 1'b0);
        set_codec_mode(MODE_DECODE);
        // two-character tail
        send_chars("QQ", 1'b1);
        stall_pct = 0;
    endtask

    // random sequences; decoding mostly sends alphabet characters with some noise
    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int         sent;
        int         seq_len;
        bit         quiet;
        bit         cut_short;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
                set_codec_mode(codec_mode_t'($urandom_range(0, 1)));
            // some sequences run with no idling at all
            quiet     = ($urandom_range(0, 3) == 0);
            gap_pct   = quiet ? 0 : tx_pct;
            stall_pct = quiet ? 0 : rx_pct;
            seq_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
            // now and then a sequence stops without its last word
            cut_short = ($urandom_range(0, 15) == 0);
            for (int k = 0; k < seq_len; k++)
            begin
                if (pred_mode == MODE_ENCODE || $urandom_range(0, 9) == 0)
                    b = 8'($urandom);
                else
                    b = b64_char_of(6'($urandom));
                if ($urandom_range(0, 39) == 0)
                    wait_results_drained();
                send_word(b, (k == seq_len - 1) && !cut_short);
            end
            sent += seq_len;
        end
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_mode_register();
        test_encode_directed();
        test_decode_directed();
        test_random_traffic(450, 20, 10);
        test_random_traffic(450, 0, 25);
        test_random_traffic(300, 40, 0);
        // closing stretch at full rate on both sides
        test_random_traffic(300, 0, 0);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
